@@ hdl/ggsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ggsc_pkg
// Shared types, constants and the arctangent table for the steering controller.
// ----------------------------------------------------------------------------
package ggsc_pkg;

    localparam int ITERATIONS_DEF = 14;
    localparam int SQRT_STEPS     = 17;
    localparam int XW             = 28;
    localparam int ZW             = 24;
    localparam int SQW            = 34;
    localparam int RW             = 35;
    localparam int CFG_AW         = 8;

    localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
    localparam logic [SQW-1:0]       NEAR_SQ_Q24 = 34'd167772;
    localparam logic [16:0]          TURN_THRESH = 17'd819;

    typedef enum logic [CFG_AW-1:0] {
        REG_GOAL_X      = 8'd0,
        REG_GOAL_Y      = 8'd1,
        REG_SPEED_GAIN  = 8'd2,
        REG_SPEED_LIMIT = 8'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [RW-1:0]        rem;
        logic [RW-1:0]        root;
        logic signed [14:0]   hd;
        logic                 far;
    } t_stage;

    function automatic logic signed [ZW-1:0] f_atan(input int unsigned i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 24'sd823550;
            1:  v = 24'sd486170;
            2:  v = 24'sd256879;
            3:  v = 24'sd130396;
            4:  v = 24'sd65451;
            5:  v = 24'sd32757;
            6:  v = 24'sd16383;
            7:  v = 24'sd8192;
            8:  v = 24'sd4096;
            9:  v = 24'sd2048;
            10: v = 24'sd1024;
            11: v = 24'sd512;
            12: v = 24'sd256;
            13: v = 24'sd128;
            14: v = 24'sd64;
            15: v = 24'sd32;
            16: v = 24'sd16;
            17: v = 24'sd8;
            18: v = 24'sd4;
            19: v = 24'sd2;
            20: v = 24'sd1;
            21: v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/ggsc_stage.sv @@
// ----------------------------------------------------------------------------
// ggsc_stage
// One pipeline stage: a CORDIC vectoring step (if IDX < ITERS) and one root digit (if IDX < SQRT_STEPS).
// ----------------------------------------------------------------------------
module ggsc_stage #(
    parameter int IDX   = 0,
    parameter int ITERS = 14
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  ggsc_pkg::t_stage i_data,
    output logic            o_valid,
    output ggsc_pkg::t_stage o_data
);
    import ggsc_pkg::*;

    localparam logic [RW-1:0] BIT = (IDX < SQRT_STEPS) ?
        (RW'(1) << (2 * (SQRT_STEPS - 1 - IDX))) : '0;

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;
    logic [RW-1:0] w_trial;

    always_comb begin
        n_data  = i_data;
        w_trial = i_data.root + BIT;
        if (IDX < ITERS) begin
            if (i_data.y >= 0) begin
                n_data.x = i_data.x + (i_data.y >>> IDX);
                n_data.y = i_data.y - (i_data.x >>> IDX);
                n_data.z = i_data.z + f_atan(IDX);
            end else begin
                n_data.x = i_data.x - (i_data.y >>> IDX);
                n_data.y = i_data.y + (i_data.x >>> IDX);
                n_data.z = i_data.z - f_atan(IDX);
            end
        end
        if (IDX < SQRT_STEPS) begin
            if (i_data.rem >= w_trial) begin
                n_data.rem  = i_data.rem - w_trial;
                n_data.root = (i_data.root >> 1) + BIT;
            end else begin
                n_data.root = i_data.root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

@@ hdl/ggsc_tail.sv @@
// ----------------------------------------------------------------------------
// ggsc_tail
// Bearing error, speed product and final selection, two register stages.
// ----------------------------------------------------------------------------
module ggsc_tail (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  ggsc_pkg::t_stage i_data,
    input  logic [15:0]      i_speed_gain,
    input  logic [15:0]      i_speed_limit,
    output logic             o_valid,
    output logic [15:0]      o_forward_speed,
    output logic [14:0]      o_turn_rate
);
    import ggsc_pkg::*;

    logic signed [ZW-1:0] w_zr;
    logic signed [15:0]   w_bearing;
    logic signed [16:0]   w_err;
    logic [16:0]          n_abs;
    logic [32:0]          n_prod;

    logic        r_valid1;
    logic        r_far1;
    logic [16:0] r_abs1;
    logic [20:0] r_speed1;
    logic        r_valid2;
    logic [15:0] r_fwd;
    logic [14:0] r_turn;

    always_comb begin
        w_zr      = i_data.z + ZW'(128);
        w_bearing = 16'(w_zr >>> 8);
        w_err     = 17'(w_bearing) - 17'(i_data.hd);
        n_abs     = w_err[16] ? 17'(-w_err) : 17'(w_err);
        n_prod    = 33'(i_speed_gain) * 33'(i_data.root[16:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_far1   <= i_data.far;
            r_abs1   <= n_abs;
            r_speed1 <= n_prod[32:12];
            r_fwd    <= '0;
            r_turn   <= '0;
            if (r_far1) begin
                if (r_abs1 > TURN_THRESH) begin
                    r_turn <= r_abs1[14:0];
                end else if (r_speed1 > 21'(i_speed_limit)) begin
                    r_fwd <= i_speed_limit;
                end else begin
                    r_fwd <= r_speed1[15:0];
                end
            end
        end
    end

    assign o_valid         = r_valid2;
    assign o_forward_speed = r_fwd;
    assign o_turn_rate     = r_turn;
endmodule

@@ hdl/go_to_goal_steering_controller_top.sv @@
// ----------------------------------------------------------------------------
// go_to_goal_steering_controller_top
// Proportional go-to-goal controller: CORDIC bearing, root distance, select.
// ----------------------------------------------------------------------------
// Path: goal difference register, CORDIC setup register, the stage chain, then the tail registers.
// Throughput: one beat per cycle; the whole pipeline stalls only while the
// output register holds a beat that is not taken.
// Reset: synchronous active low; clears valids and loads register defaults.
// ----------------------------------------------------------------------------
module go_to_goal_steering_controller_top #(
    parameter int ITERATIONS = ggsc_pkg::ITERATIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16], heading[46:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // forward_speed[15:0], turn_rate[30:16]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ggsc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [15:0] i_cfg_data
);
    import ggsc_pkg::*;

    localparam int L = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS;

    logic [15:0] r_goal_x, r_goal_y, r_gain, r_limit;
    logic        w_en;

    logic               r_v1;
    logic signed [16:0] r_dx, r_dy;
    logic signed [14:0] r_hd1;
    logic               r_v2;
    t_stage             r_s2;
    t_stage             n_s2;
    logic signed [33:0] w_sq;
    logic signed [XW-1:0] w_x0, w_y0;

    logic   w_valid [L+1];
    t_stage w_data  [L+1];

    logic        w_out_valid;
    logic [15:0] w_fwd;
    logic [14:0] w_turn;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= 16'd4096;
            r_goal_y <= 16'd4096;
            r_gain   <= 16'd4096;
            r_limit  <= 16'd12288;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_GOAL_X:      r_goal_x <= i_cfg_data;
                REG_GOAL_Y:      r_goal_y <= i_cfg_data;
                REG_SPEED_GAIN:  r_gain   <= i_cfg_data;
                REG_SPEED_LIMIT: r_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
        end
    end

    always_comb begin
        w_sq = 34'(r_dx) * 34'(r_dx) + 34'(r_dy) * 34'(r_dy);
        w_x0 = XW'(r_dx) <<< 8;
        w_y0 = XW'(r_dy) <<< 8;
        n_s2      = '0;
        n_s2.hd   = r_hd1;
        n_s2.rem  = RW'(unsigned'(w_sq));
        n_s2.far  = unsigned'(w_sq) > NEAR_SQ_Q24;
        n_s2.x    = w_x0;
        n_s2.y    = w_y0;
        if (w_x0 < 0) begin
            if (w_y0 >= 0) begin
                n_s2.x = w_y0;
                n_s2.y = -w_x0;
                n_s2.z = HALF_PI_Q20;
            end else begin
                n_s2.x = -w_y0;
                n_s2.y = w_x0;
                n_s2.z = -HALF_PI_Q20;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx  <= $signed({1'b0, r_goal_x}) - $signed({1'b0, s_axis_tdata[15:0]});
            r_dy  <= $signed({1'b0, r_goal_y}) - $signed({1'b0, s_axis_tdata[31:16]});
            r_hd1 <= s_axis_tdata[46:32];
            r_s2  <= n_s2;
        end
    end

    assign w_valid[0] = r_v2;
    assign w_data[0]  = r_s2;

    for (genvar g = 0; g < L; g++) begin : g_stage
        ggsc_stage #(
            .IDX   (g),
            .ITERS (ITERATIONS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    ggsc_tail u_tail (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_valid         (w_valid[L]),
        .i_data          (w_data[L]),
        .i_speed_gain    (r_gain),
        .i_speed_limit   (r_limit),
        .o_valid         (w_out_valid),
        .o_forward_speed (w_fwd),
        .o_turn_rate     (w_turn)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {1'b0, w_turn, w_fwd};
endmodule

@@ hdl/ggsc_checker.sv @@
// ----------------------------------------------------------------------------
// ggsc_checker
// Port-level checks for the steering controller, bound to the top level.
// ----------------------------------------------------------------------------
module ggsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[30:16] != 15'd0) |-> m_axis_tdata[15:0] == 16'd0)
        else $error("turn and drive commanded together");

    a_turn_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[30:16] != 15'd0) |-> m_axis_tdata[30:16] > 15'd819)
        else $error("turn rate below threshold");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
endmodule

bind go_to_goal_steering_controller_top ggsc_checker u_ggsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
